// File: hdl/nsct_pkg.sv
// Shared types and constants of the NRU cache tag store.
`timescale 1ns / 1ps
package nsct_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TAG_W       = 26;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned OUT_WAY_W   = 3;
  localparam int unsigned BUCKET_W    = 4;
  localparam int unsigned HIST_N      = 16;
  localparam int unsigned BUCKET_TOP  = 15;
  localparam int unsigned OUT_TDATA_W = 136;

  // APB register map
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic        REG_LINE_OFFSET = 1'b0;  // paddr[2] of the offset register
  localparam logic [CFG_W-1:0] LINE_OFFSET_RST = 4'd6;

  // Parameter defaults
  localparam int unsigned SET_BITS_DEF  = 6;
  localparam int unsigned WAYS_DEF      = 8;
  localparam int unsigned REUSE_MAX_DEF = 15;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } nsct_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch the address beat and read the set row
    logic commit;  // write back the row and load the result register
  } nsct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;  // result register holds a beat that is not being taken
  } nsct_status_t;

endpackage

// File: hdl/nsct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nsct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/nsct_ctrl.sv
// Sequencer of the tag store: accept, row lookup, write-back.
`timescale 1ns / 1ps
module nsct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nsct_pkg::nsct_status_t status_i,
  output nsct_pkg::nsct_cmd_t    cmd_o
);
  import nsct_pkg::*;

  nsct_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status_i.out_blocked) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.start  = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.commit = !status_i.out_blocked;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/nsct_datapath.sv
// Set row lookup, NRU victim choice, row update, histogram and counters.
`timescale 1ns / 1ps
module nsct_datapath #(
  parameter int unsigned SET_BITS  = nsct_pkg::SET_BITS_DEF,
  parameter int unsigned WAYS      = nsct_pkg::WAYS_DEF,
  parameter int unsigned REUSE_MAX = nsct_pkg::REUSE_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [nsct_pkg::CFG_W-1:0]      line_offset_i,
  input  logic [nsct_pkg::ADDR_W-1:0]     address_i,
  input  nsct_pkg::nsct_cmd_t             cmd_i,
  output nsct_pkg::nsct_status_t          status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nsct_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import nsct_pkg::*;

  localparam int unsigned NSETS = 1 << SET_BITS;
  localparam int unsigned SW    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned WIW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RW    = $clog2(REUSE_MAX + 1);
  localparam int unsigned ENT_W = TAG_W + 2 + RW;
  localparam int unsigned ROW_W = WAYS * ENT_W;
  // entry layout from bit 0: tag, valid, not-recent, reuse count

  // address split
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] tag_full;
  logic [SW-1:0]     set_in;
  assign shifted  = address_i >> line_offset_i;
  assign tag_full = shifted >> SET_BITS;
  assign set_in   = (SET_BITS == 0) ? '0 : shifted[SW-1:0];

  logic [SW-1:0]    set_q;
  logic [TAG_W-1:0] tag_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      set_q <= set_in;
      tag_q <= tag_full[TAG_W-1:0];
    end
  end

  // row memory
  logic [ROW_W-1:0] row_rd, row_wr;
  nsct_ram #(.WIDTH(ROW_W), .DEPTH(NSETS), .AW(SW)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.start),
    .raddr_i (set_in),
    .rdata_o (row_rd)
  );

  // rows never written read as the reset contents
  logic [NSETS-1:0] row_init_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
    end else if (cmd_i.commit) begin
      row_init_q[set_q] <= 1'b1;
    end
  end

  // unpack the row
  logic [TAG_W-1:0] tg  [WAYS];
  logic [RW-1:0]    ru  [WAYS];
  logic [WAYS-1:0]  vld, nru, hit_vec;
  logic             row_ok;
  assign row_ok = row_init_q[set_q];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w]      = row_rd[w*ENT_W +: TAG_W];
      vld[w]     = row_ok & row_rd[w*ENT_W + TAG_W];
      nru[w]     = !row_ok | row_rd[w*ENT_W + TAG_W + 1];
      ru[w]      = row_ok ? row_rd[w*ENT_W + TAG_W + 2 +: RW] : '0;
      hit_vec[w] = vld[w] && (tg[w] == tag_q);
    end
  end

  // hit and victim selection, lowest way first
  logic           hit_any, all_recent;
  logic [WIW-1:0] hit_way, inv_way, nru_way, sel_way;
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    nru_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WIW'(w);
      if (!vld[w])    inv_way = WIW'(w);
      if (nru[w])     nru_way = WIW'(w);
    end
    hit_any    = |hit_vec;
    all_recent = (&vld) && !(|nru);
    if (hit_any)       sel_way = hit_way;
    else if (!(&vld))  sel_way = inv_way;
    else if (|nru)     sel_way = nru_way;
    else               sel_way = '0;
  end

  // selected entry and eviction
  logic             sel_vld;
  logic [RW-1:0]    sel_ru;
  logic [TAG_W-1:0] sel_tag;
  logic             evict;
  logic [BUCKET_W-1:0] bucket;
  assign sel_vld = vld[sel_way];
  assign sel_ru  = ru[sel_way];
  assign sel_tag = tg[sel_way];
  assign evict   = !hit_any && sel_vld;
  assign bucket  = (32'(sel_ru) >= BUCKET_TOP) ? BUCKET_W'(BUCKET_TOP) : BUCKET_W'(sel_ru);

  // updated row
  always_comb begin
    logic [ENT_W-1:0] ent;
    row_wr = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent = {ru[w], (nru[w] | (!hit_any && all_recent)), vld[w], tg[w]};
      if (WIW'(w) == sel_way) begin
        if (hit_any) begin
          ent[TAG_W+1] = 1'b0;
          if (32'(ru[w]) < REUSE_MAX) ent[TAG_W+2 +: RW] = ru[w] + 1'b1;
        end else begin
          ent = {{RW{1'b0}}, 1'b0, 1'b1, tag_q};
        end
      end
      row_wr[w*ENT_W +: ENT_W] = ent;
    end
  end

  // histogram and counters
  logic [CNT_W-1:0] hist_q [HIST_N];
  logic [CNT_W-1:0] bucket_next, hit_cnt_q, miss_cnt_q;
  assign bucket_next = hist_q[bucket] + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_N; i++) hist_q[i] <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      if (evict)   hist_q[bucket] <= bucket_next;
      if (hit_any) hit_cnt_q  <= hit_cnt_q + 1'b1;
      else         miss_cnt_q <= miss_cnt_q + 1'b1;
    end
  end

  // result register
  logic                 out_valid_q;
  logic                 r_hit_q, r_evict_q;
  logic [OUT_WAY_W-1:0] r_way_q;
  logic [TAG_W-1:0]     r_tag_q;
  logic [BUCKET_W-1:0]  r_bucket_q;
  logic [CNT_W-1:0]     r_bcount_q, r_hits_q, r_misses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      r_hit_q    <= hit_any;
      r_way_q    <= OUT_WAY_W'(32'(sel_way));
      r_evict_q  <= evict;
      r_tag_q    <= evict ? sel_tag : '0;
      r_bucket_q <= evict ? bucket : '0;
      r_bcount_q <= evict ? bucket_next : '0;
      r_hits_q   <= hit_any ? hit_cnt_q + 1'b1 : hit_cnt_q;
      r_misses_q <= hit_any ? miss_cnt_q : miss_cnt_q + 1'b1;
    end
  end

  assign status_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = {5'd0, r_misses_q, r_hits_q, r_bcount_q, r_bucket_q,
                        r_tag_q, r_evict_q, r_way_q, r_hit_q};

endmodule

// File: hdl/nru_set_associative_cache_tags.sv
// Top level of the NRU set-associative cache tag store.
`timescale 1ns / 1ps
// Tag store of a set-associative cache with not-recently-used replacement.
// Each address beat is split by the line_offset_bits register (APB byte
// address 0, reset 6) into set index and 26-bit tag; one result beat comes
// back per access with hit, way, eviction details and running counters.
// An access reads the set row from the synchronous row RAM, then updates it
// and writes it back once the result register is free. A new address is
// taken only after the write-back, but while the previous result still
// waits on the output. No clearing pass is needed after reset: a per-set
// flag marks rows never written, which read as empty.
module nru_set_associative_cache_tags #(
  parameter int unsigned SET_BITS  = nsct_pkg::SET_BITS_DEF,
  parameter int unsigned WAYS      = nsct_pkg::WAYS_DEF,
  parameter int unsigned REUSE_MAX = nsct_pkg::REUSE_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // address beat
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [nsct_pkg::ADDR_W-1:0]        s_axis_tdata_i,  // [31:0] address
  // result beat
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] hit, [3:1] way, [4] evicted, [30:5] evicted_tag, [34:31] evicted_reuse,
  // [66:35] bucket_count, [98:67] hit_total, [130:99] miss_total, rest zero
  output logic [nsct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nsct_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nsct_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nsct_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import nsct_pkg::*;

  // configuration register
  logic [CFG_W-1:0] line_offset_q;
  logic             cfg_hit;
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_LINE_OFFSET);
  assign prdata  = cfg_hit ? APB_DATA_W'(line_offset_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_offset_q <= LINE_OFFSET_RST;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      line_offset_q <= pwdata[CFG_W-1:0];
    end
  end

  nsct_cmd_t    cmd;
  nsct_status_t status;

  nsct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nsct_datapath #(
    .SET_BITS  (SET_BITS),
    .WAYS      (WAYS),
    .REUSE_MAX (REUSE_MAX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_offset_i (line_offset_q),
    .address_i     (s_axis_tdata_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted beat blocks the input until its lookup is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready during lookup");

  // a write-back never overwrites a pending result beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("result overwritten");

  // a new result only follows a write-back
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.commit))
    else $error("result without lookup");
`endif

endmodule
